### sv/crt_pkg.sv
package crt_pkg;

  localparam int unsigned InW   = 32;
  localparam int unsigned OffW  = InW + 1;
  localparam int unsigned SqW   = 2 * OffW;
  localparam int unsigned RootW = OffW;

  typedef enum logic [1:0] {
    QUAD_1 = 2'd0,
    QUAD_2 = 2'd1,
    QUAD_3 = 2'd2,
    QUAD_4 = 2'd3
  } quad_e;

  typedef struct packed {
    logic                   deg;
    logic signed [OffW-1:0] px;
    logic signed [OffW-1:0] py;
    logic signed [OffW-1:0] dcx;
    logic signed [OffW-1:0] dcy;
  } side_t;

  function automatic quad_e quadrant(input logic xneg, input logic yneg);
    quad_e q;
    if (!xneg && !yneg) q = QUAD_1;
    else if (xneg && !yneg) q = QUAD_2;
    else if (xneg && yneg) q = QUAD_3;
    else q = QUAD_4;
    return q;
  endfunction

  function automatic logic [OffW-1:0] mag(input logic signed [OffW-1:0] v);
    return v[OffW-1] ? OffW'(-v) : OffW'(v);
  endfunction

endpackage

### sv/crt_isqrt.sv
module crt_isqrt (
  input  logic                       clk_i,
  input  logic [crt_pkg::SqW-1:0]    n_i,
  output logic [crt_pkg::RootW-1:0]  root_o
);
  import crt_pkg::*;

  localparam int unsigned NS = RootW;
  localparam int unsigned RW = RootW + 3;

  logic [RW-1:0]    rem_q  [NS];
  logic [RootW-1:0] root_q [NS];
  logic [SqW-1:0]   n_q    [NS];

  for (genvar g = 0; g < NS; g++) begin : g_step
    logic [RW-1:0]    rem_in, rem_s, t;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   n_in;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign n_in    = n_q[g-1];
    end

    assign rem_s = {rem_in[RW-3:0], n_in[SqW-1 -: 2]};
    assign t     = {1'b0, root_in, 2'b01};
    assign ge    = rem_s >= t;

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? RW'(rem_s - t) : rem_s;
      root_q[g] <= {root_in[RootW-2:0], ge};
      n_q[g]    <= {n_in[SqW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[NS-1];

endmodule

### sv/crt_div.sv
module crt_div (
  input  logic                       clk_i,
  input  logic [crt_pkg::SqW-1:0]    num_i,
  input  logic [crt_pkg::RootW-1:0]  den_i,
  output logic [crt_pkg::RootW-1:0]  quo_o
);
  import crt_pkg::*;

  localparam int unsigned NS = RootW;

  logic [RootW-1:0] rem_q [NS];
  logic [RootW-1:0] quo_q [NS];
  logic [RootW-1:0] n_q   [NS];
  logic [RootW-1:0] den_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_step
    logic [RootW-1:0] rem_in, quo_in, n_in, den_in;
    logic [RootW:0]   rem_s, dx;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = num_i[SqW-1:RootW];
      assign quo_in = '0;
      assign n_in   = num_i[RootW-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
      assign n_in   = n_q[g-1];
      assign den_in = den_q[g-1];
    end

    assign rem_s = {rem_in, n_in[RootW-1]};
    assign dx    = {1'b0, den_in};
    assign ge    = rem_s >= dx;

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? RootW'(rem_s - dx) : rem_s[RootW-1:0];
      quo_q[g] <= {quo_in[RootW-2:0], ge};
      n_q[g]   <= {n_in[RootW-2:0], 1'b0};
      den_q[g] <= den_in;
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

### sv/ccw_rotation_test_2d.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// command  | start_i, busy_o        | centre_*_i, first_*_i, second_*_i
// result   | done_o (one-cycle)     | is_ccw_o, degenerate_o
//
// One transfer per cycle; busy_o stays low, a new item may start every cycle.
// Stages in order: input, square, sum, 33-step root, product, 33-step
// divide, decision. The root and divide bit steps set the depth.
// rst_ni clears the valid line only; data registers carry no reset.
// The receiver cannot stall; done_o pulses once per item.
module ccw_rotation_test_2d (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [crt_pkg::InW-1:0]  centre_x_i,
  input  logic signed [crt_pkg::InW-1:0]  centre_y_i,
  input  logic signed [crt_pkg::InW-1:0]  first_x_i,
  input  logic signed [crt_pkg::InW-1:0]  first_y_i,
  input  logic signed [crt_pkg::InW-1:0]  second_x_i,
  input  logic signed [crt_pkg::InW-1:0]  second_y_i,
  output logic                            done_o,
  output logic                            is_ccw_o,
  output logic                            degenerate_o
);
  import crt_pkg::*;

  localparam int unsigned NSide = 3 + 2 * RootW + 1;
  localparam int unsigned IdxR  = 2 + RootW;
  localparam int unsigned Lat   = NSide + 1;

  logic           vld_q  [NSide];
  side_t          side_q [NSide];
  side_t          side_d;
  logic [SqW-1:0] sq_px_q, sq_py_q, sq_cx_q, sq_cy_q;
  logic [SqW-1:0] sum_p_q, sum_c_q;
  logic [RootW-1:0] r_w, len_w, len_q, qx_w, qy_w;
  logic [SqW-1:0] prod_x_q, prod_y_q;
  logic done_q, ccw_q, deg_q, ccw_d;

  assign busy_o = 1'b0;

  always_comb begin
    side_d.px  = OffW'(first_x_i) - OffW'(centre_x_i);
    side_d.py  = OffW'(first_y_i) - OffW'(centre_y_i);
    side_d.dcx = OffW'(second_x_i) - OffW'(centre_x_i);
    side_d.dcy = OffW'(second_y_i) - OffW'(centre_y_i);
    side_d.deg = (second_x_i == centre_x_i) && (second_y_i == centre_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSide; i++) vld_q[i] <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < NSide; i++) vld_q[i] <= vld_q[i-1];
      done_q <= vld_q[NSide-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < NSide; i++) side_q[i] <= side_q[i-1];
    sq_px_q  <= mag(side_q[0].px) * mag(side_q[0].px);
    sq_py_q  <= mag(side_q[0].py) * mag(side_q[0].py);
    sq_cx_q  <= mag(side_q[0].dcx) * mag(side_q[0].dcx);
    sq_cy_q  <= mag(side_q[0].dcy) * mag(side_q[0].dcy);
    sum_p_q  <= sq_px_q + sq_py_q;
    sum_c_q  <= sq_cx_q + sq_cy_q;
    prod_x_q <= mag(side_q[IdxR].dcx) * r_w;
    prod_y_q <= mag(side_q[IdxR].dcy) * r_w;
    len_q    <= len_w;
  end

  crt_isqrt u_sqrt_r (.clk_i(clk_i), .n_i(sum_p_q), .root_o(r_w));
  crt_isqrt u_sqrt_l (.clk_i(clk_i), .n_i(sum_c_q), .root_o(len_w));
  crt_div   u_div_x  (.clk_i(clk_i), .num_i(prod_x_q), .den_i(len_q), .quo_o(qx_w));
  crt_div   u_div_y  (.clk_i(clk_i), .num_i(prod_y_q), .den_i(len_q), .quo_o(qy_w));

  side_t lst;
  logic signed [OffW:0] sx, sy, px, py;
  logic [OffW:0] mpx, mpy, msx, msy;
  quad_e kp, ks;

  always_comb begin
    lst = side_q[NSide-1];
    px  = (OffW+1)'(lst.px);
    py  = (OffW+1)'(lst.py);
    sx  = lst.dcx[OffW-1] ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
    sy  = lst.dcy[OffW-1] ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});
    mpx = px[OffW] ? (OffW+1)'(-px) : px;
    mpy = py[OffW] ? (OffW+1)'(-py) : py;
    msx = {1'b0, qx_w};
    msy = {1'b0, qy_w};
    kp  = quadrant(px[OffW], py[OffW]);
    ks  = quadrant(sx[OffW], sy[OffW]);
    ccw_d = 1'b0;
    if (kp == ks) begin
      ccw_d = (kp == QUAD_1 || kp == QUAD_2) ? (px > sx) : (px < sx);
    end else if (ks == quad_e'(kp + 2'd1)) begin
      ccw_d = 1'b1;
    end else if ((kp == QUAD_1 && ks == QUAD_3) || (kp == QUAD_3 && ks == QUAD_1)) begin
      ccw_d = mpy >= msy;
    end else if ((kp == QUAD_2 && ks == QUAD_4) || (kp == QUAD_4 && ks == QUAD_2)) begin
      ccw_d = mpx >= msx;
    end
    if (lst.deg) ccw_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    ccw_q <= ccw_d;
    deg_q <= lst.deg;
  end

  assign done_o       = done_q;
  assign is_ccw_o     = ccw_q;
  assign degenerate_o = deg_q;

  a_deg_no_ccw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> !is_ccw_o)
    else $error("degenerate result flagged ccw");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without matching start");

  a_deg_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> degenerate_o ==
      $past(second_x_i == centre_x_i && second_y_i == centre_y_i, Lat))
    else $error("degenerate flag mismatch");

endmodule

### tb/ccw_checker.sv
module ccw_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_o,
  input  logic signed [crt_pkg::InW-1:0] centre_x_i,
  input  logic signed [crt_pkg::InW-1:0] centre_y_i,
  input  logic signed [crt_pkg::InW-1:0] first_x_i,
  input  logic signed [crt_pkg::InW-1:0] first_y_i,
  input  logic signed [crt_pkg::InW-1:0] second_x_i,
  input  logic signed [crt_pkg::InW-1:0] second_y_i,
  input  logic                           done_o,
  input  logic                           is_ccw_o,
  input  logic                           degenerate_o,
  output int                             fail_count,
  output int                             pending
);
  import crt_pkg::*;

  typedef struct packed {
    logic ccw;
    logic deg;
  } verdict_t;

  verdict_t verdict_q[$];

  function automatic logic [OffW-1:0] abs_off(input logic signed [OffW-1:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [RootW-1:0] root_floor(input logic [SqW:0] n);
    logic [RootW:0] r;
    logic [RootW:0] c;
    r = '0;
    for (int b = RootW; b >= 0; b--) begin
      c = r | ((RootW+1)'(1) << b);
      if ((2*RootW+2)'(c) * (2*RootW+2)'(c) <= (2*RootW+2)'(n)) r = c;
    end
    return r[RootW-1:0];
  endfunction

  function automatic logic signed [OffW:0] scale_off(input logic signed [OffW-1:0] d,
                                                    input logic [RootW-1:0] r,
                                                    input logic [RootW-1:0] len);
    logic [2*OffW+1:0] prod;
    logic [2*OffW+1:0] q;
    prod = (2*OffW+2)'(abs_off(d)) * (2*OffW+2)'(r);
    q = prod / len;
    return d < 0 ? -$signed((OffW+1)'(q)) : $signed((OffW+1)'(q));
  endfunction

  function automatic quad_e quad_of(input logic xneg, input logic yneg);
    if (!xneg && !yneg) return QUAD_1;
    if (xneg && !yneg) return QUAD_2;
    if (xneg && yneg) return QUAD_3;
    return QUAD_4;
  endfunction

  function automatic verdict_t predict_turn(input logic signed [InW-1:0] qx, qy, px0, py0,
                                            cx, cy);
    logic signed [OffW-1:0] px, py, dx, dy;
    logic signed [OffW:0] sx, sy, pxe;
    logic [SqW:0] rsq, lsq;
    logic [RootW-1:0] r, len;
    quad_e kp, ks;
    verdict_t v;
    px = OffW'(px0) - OffW'(qx);
    py = OffW'(py0) - OffW'(qy);
    dx = OffW'(cx) - OffW'(qx);
    dy = OffW'(cy) - OffW'(qy);
    v = '0;
    if (dx == 0 && dy == 0) begin
      v.deg = 1'b1;
      return v;
    end
    rsq = (SqW+1)'(abs_off(px)) * abs_off(px) + (SqW+1)'(abs_off(py)) * abs_off(py);
    lsq = (SqW+1)'(abs_off(dx)) * abs_off(dx) + (SqW+1)'(abs_off(dy)) * abs_off(dy);
    r = root_floor(rsq);
    len = root_floor(lsq);
    sx = scale_off(dx, r, len);
    sy = scale_off(dy, r, len);
    pxe = px;
    kp = quad_of(px < 0, py < 0);
    ks = quad_of(sx < 0, sy < 0);
    if (kp == ks)
      v.ccw = (kp == QUAD_1 || kp == QUAD_2) ? (pxe > sx) : (pxe < sx);
    else if (ks == quad_e'(kp + 2'd1))
      v.ccw = 1'b1;
    else if ((kp == QUAD_1 && ks == QUAD_3) || (kp == QUAD_3 && ks == QUAD_1))
      v.ccw = (py < 0 ? -$signed({py[OffW-1], py}) : {py[OffW-1], py}) >=
              (sy < 0 ? -sy : sy);
    else if ((kp == QUAD_2 && ks == QUAD_4) || (kp == QUAD_4 && ks == QUAD_2))
      v.ccw = (pxe < 0 ? -pxe : pxe) >= (sx < 0 ? -sx : sx);
    return v;
  endfunction

  assign pending = verdict_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (start_i && !busy_o)
        verdict_q.push_back(predict_turn(centre_x_i, centre_y_i, first_x_i, first_y_i,
                                         second_x_i, second_y_i));
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer");
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want.ccw !== is_ccw_o || want.deg !== degenerate_o) begin
            if (fail_count < 10)
              $display("mismatch: exp ccw=%0d deg=%0d, got ccw=%0d deg=%0d",
                       want.ccw, want.deg, is_ccw_o, degenerate_o);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb_ccw_rotation_test_2d.sv
module tb_ccw_rotation_test_2d;
  import crt_pkg::*;

  localparam int Latency = 71;
  localparam int StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, is_ccw_o, degenerate_o;
  logic signed [InW-1:0] centre_x_i = '0, centre_y_i = '0, first_x_i = '0;
  logic signed [InW-1:0] first_y_i = '0, second_x_i = '0, second_y_i = '0;
  int fail_count, pending;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  ccw_rotation_test_2d dut (.*);

  ccw_checker u_checker (.*);

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [InW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 64) - 32;
      3: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [InW-1:0] qx, qy, px, py, cx, cy);
    start_i <= 1'b1;
    centre_x_i <= qx;
    centre_y_i <= qy;
    first_x_i <= px;
    first_y_i <= py;
    second_x_i <= cx;
    second_y_i <= cy;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_random();
    logic [InW-1:0] qx, qy;
    qx = rand_coord();
    qy = rand_coord();
    case ($urandom_range(0, 9))
      0: send_item(qx, qy, rand_coord(), rand_coord(), qx, qy);
      1: send_item(qx, qy, qx, qy, rand_coord(), rand_coord());
      2: send_item(qx, qy, qx + ($urandom_range(0, 8) - 4), qy + ($urandom_range(0, 8) - 4),
                   qx + ($urandom_range(0, 8) - 4), qy + ($urandom_range(0, 8) - 4));
      default: send_item(qx, qy, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endcase
  endtask

  initial begin
    logic [InW-1:0] mx, mn;
    int gap;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(0, 0, 32'h1_0000, 0, 0, 32'h1_0000);
    send_item(0, 0, 0, 32'h1_0000, 32'h1_0000, 0);
    send_item(0, 0, 32'h1_0000, 32'h1_0000, 32'h2_0000, 32'h1_0000);
    send_item(0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h2_0000);
    send_item(0, 0, -32'sd5, 3, -32'sd3, 5);
    send_item(0, 0, -32'sd5, -32'sd3, -32'sd3, -32'sd5);
    send_item(0, 0, 5, -32'sd3, 3, -32'sd5);
    send_item(0, 0, 4, 4, -32'sd4, -32'sd4);
    send_item(0, 0, -32'sd4, -32'sd4, 4, 4);
    send_item(0, 0, -32'sd4, 4, 4, -32'sd4);
    send_item(0, 0, 4, -32'sd4, -32'sd4, 4);
    send_item(7, 7, 9, 9, 7, 7);
    send_item(7, 7, 7, 7, 9, 3);
    send_item(mn, mn, mx, mx, mx, mn);
    send_item(mx, mx, mn, mn, mn, mx);
    send_item(mx, mn, mn, mx, mx, mx);
    send_item(mn, mx, mx, mn, mn, mn);
    send_item(0, 0, 1, 0, 0, mx);
    send_item(mx, mx, mx, mx, mx, mx);
    send_item(0, 0, mn, mx, mx, 1);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 1400; ) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      for (int k = 0; k < gap && i < 1400; k++, i++) send_random();
      if (i == 700) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 1)) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
